[hdl/lbps_pkg.sv]
// Shared types, constants and blink pattern table for the LED blink pattern sequencer.
package lbps_pkg;

    localparam int unsigned TABLE_ROWS  = 16;
    localparam int unsigned PHASE_SLOTS = 8;
    localparam int unsigned SEL_W       = $clog2(TABLE_ROWS);
    localparam int unsigned PHASE_W     = $clog2(PHASE_SLOTS);
    localparam int unsigned CNT_W       = 8;

    // Patterns at or above this number play as the empty pattern
    localparam logic [SEL_W:0]   NUM_PATTERNS = (SEL_W + 1)'(11);
    // Phase counts above this are clipped
    localparam logic [PHASE_W:0] MAX_PHASES   = (PHASE_W + 1)'(6);

    // One input item
    typedef struct packed {
        logic             func;
        logic [SEL_W-1:0] mode;
    } item_t;

    typedef enum logic {
        FUNC_TICK = 1'b0,
        FUNC_SET  = 1'b1
    } func_t;

    localparam logic [PHASE_W:0] ROW_PHASES [TABLE_ROWS] = '{
        4'd0, 4'd2, 4'd2, 4'd2, 4'd2, 4'd0, 4'd0, 4'd6,
        4'd6, 4'd6, 4'd2, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0
    };

    localparam logic [CNT_W-1:0] ROW_REPEATS [TABLE_ROWS] = '{
        8'd0, 8'd0, 8'd1, 8'd3, 8'd1, 8'd0, 8'd0, 8'd3,
        8'd3, 8'd1, 8'd6, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
    };

    localparam logic [CNT_W-1:0] ROW_LEN [TABLE_ROWS][PHASE_SLOTS] = '{
        '{8'd0,  8'd0, 8'd0, 8'd0, 8'd0, 8'd0,  8'd0, 8'd0},
        '{8'd5,  8'd5, 8'd0, 8'd0, 8'd0, 8'd0,  8'd0, 8'd0},
        '{8'd20, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,  8'd0, 8'd0},
        '{8'd1,  8'd1, 8'd0, 8'd0, 8'd0, 8'd0,  8'd0, 8'd0},
        '{8'd1,  8'd1, 8'd0, 8'd0, 8'd0, 8'd0,  8'd0, 8'd0},
        '{8'd0,  8'd0, 8'd0, 8'd0, 8'd0, 8'd0,  8'd0, 8'd0},
        '{8'd0,  8'd0, 8'd0, 8'd0, 8'd0, 8'd0,  8'd0, 8'd0},
        '{8'd5,  8'd1, 8'd1, 8'd1, 8'd1, 8'd10, 8'd0, 8'd0},
        '{8'd1,  8'd1, 8'd1, 8'd1, 8'd1, 8'd10, 8'd0, 8'd0},
        '{8'd1,  8'd1, 8'd5, 8'd1, 8'd5, 8'd10, 8'd0, 8'd0},
        '{8'd2,  8'd2, 8'd0, 8'd0, 8'd0, 8'd0,  8'd0, 8'd0},
        '{8'd0,  8'd0, 8'd0, 8'd0, 8'd0, 8'd0,  8'd0, 8'd0},
        '{8'd0,  8'd0, 8'd0, 8'd0, 8'd0, 8'd0,  8'd0, 8'd0},
        '{8'd0,  8'd0, 8'd0, 8'd0, 8'd0, 8'd0,  8'd0, 8'd0},
        '{8'd0,  8'd0, 8'd0, 8'd0, 8'd0, 8'd0,  8'd0, 8'd0},
        '{8'd0,  8'd0, 8'd0, 8'd0, 8'd0, 8'd0,  8'd0, 8'd0}
    };

    // Phase count of a row, clipped to the phase limit
    function automatic logic [PHASE_W:0] row_phases(input logic [SEL_W-1:0] sel);
        logic [PHASE_W:0] n;
        n = ROW_PHASES[sel];
        if (n > MAX_PHASES) begin
            n = MAX_PHASES;
        end
        return n;
    endfunction

endpackage

[hdl/led_blink_pattern_sequencer.sv]
// Top level of the LED blink pattern sequencer.
//
// Input channel (s_valid/s_ready, s_func, s_mode): each item is either a
// timer tick (func 0) or a pattern select (func 1, mode = pattern number).
// Result channel (m_valid/m_ready, m_led_on, m_active): exactly one result
// per item, in order, giving the LED level and whether a pattern still plays.
//
// An accepted item is held in the input register; the core then
// applies the table lookup and counter update and loads the state, which is
// also the result register. An item thus passes the input register and
// then the state register before its result is valid. Throughput is one
// item per cycle while the receiver takes each result; a stall on m_ready
// holds the flow.
//
// Reset (aresetn low at a clock edge) empties both stages and returns the
// state to idle: empty pattern, LED off, not playing.
// When the receiver stalls, the result holds; one more item may still be
// taken into the input register, after which s_ready drops until the
// result is taken.
module led_blink_pattern_sequencer (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_func,
    input  logic [3:0] s_mode,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_led_on,
    output logic       m_active
);

    lbps_pkg::item_t s_item;
    lbps_pkg::item_t item;
    logic            item_valid;
    logic            take;

    assign s_item.func = s_func;
    assign s_item.mode = s_mode;

    lbps_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    lbps_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_led_on   (m_led_on),
        .m_active   (m_active)
    );

endmodule

[hdl/lbps_in_stage.sv]
// Input register stage: holds one accepted item until the core takes it.
module lbps_in_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  lbps_pkg::item_t      s_item,
    input  logic                 take,
    output logic                 item_valid,
    output lbps_pkg::item_t      item
);

    logic            in_valid_reg;
    logic            in_valid_next;
    lbps_pkg::item_t item_reg;

    // Free when empty or when the held item leaves this cycle
    assign s_ready = !in_valid_reg || take;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (take) begin
            in_valid_next = 1'b0;
        end
    end

    // Hold the valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Capture the payload on accept
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = in_valid_reg;
    assign item       = item_reg;

    a_take_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        take |-> in_valid_reg)
        else $error("core took an item from an empty input stage");

    a_full_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg)
        else $error("input stage refused an item while empty");

    a_held_item_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !take) |=> (in_valid_reg && $stable(item_reg)))
        else $error("held item changed before it was taken");

endmodule

[hdl/lbps_core.sv]
// Pattern state, next-state logic and the result register.
module lbps_core (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            item_valid,
    input  lbps_pkg::item_t item,
    output logic            take,
    output logic            m_valid,
    input  logic            m_ready,
    output logic            m_led_on,
    output logic            m_active
);

    logic [lbps_pkg::SEL_W-1:0]   pattern_sel_reg,  pattern_sel_next;
    logic [lbps_pkg::PHASE_W-1:0] phase_index_reg,  phase_index_next;
    logic [lbps_pkg::CNT_W-1:0]   repeat_count_reg, repeat_count_next;
    logic [lbps_pkg::CNT_W-1:0]   ticks_left_reg,   ticks_left_next;
    logic                         led_level_reg,    led_level_next;
    logic                         playing_reg,      playing_next;
    logic                         m_valid_reg,      m_valid_next;

    logic [lbps_pkg::SEL_W-1:0]   sel_new;
    logic [lbps_pkg::PHASE_W:0]   phases_cur;
    logic [lbps_pkg::PHASE_W:0]   phase_inc;
    logic [lbps_pkg::CNT_W-1:0]   reps_cur;
    logic [lbps_pkg::CNT_W-1:0]   rep_inc;

    // Advance when an item waits and the result slot is free
    assign take = item_valid && (!m_valid_reg || m_ready);

    always_comb begin
        sel_new = ({1'b0, item.mode} >= lbps_pkg::NUM_PATTERNS) ? '0 : item.mode;
        phases_cur = lbps_pkg::row_phases(pattern_sel_reg);
        phase_inc  = {1'b0, phase_index_reg} + 1'b1;
        reps_cur   = lbps_pkg::ROW_REPEATS[pattern_sel_reg];
        rep_inc    = repeat_count_reg + 1'b1;

        pattern_sel_next  = pattern_sel_reg;
        phase_index_next  = phase_index_reg;
        repeat_count_next = repeat_count_reg;
        ticks_left_next   = ticks_left_reg;
        led_level_next    = led_level_reg;
        playing_next      = playing_reg;

        priority if (item.func == lbps_pkg::FUNC_SET) begin
            // Drop the running pattern and start the new one if it has any phases
            pattern_sel_next  = sel_new;
            phase_index_next  = '0;
            repeat_count_next = '0;
            ticks_left_next   = '0;
            led_level_next    = 1'b0;
            playing_next      = 1'b0;
            if (lbps_pkg::row_phases(sel_new) != '0) begin
                playing_next    = 1'b1;
                ticks_left_next = lbps_pkg::ROW_LEN[sel_new][0];
                led_level_next  = 1'b1;
            end
        end else if (playing_reg) begin
            priority if (ticks_left_reg > lbps_pkg::CNT_W'(1)) begin
                // Count down the current phase
                ticks_left_next = ticks_left_reg - 1'b1;
            end else if (phase_inc < phases_cur) begin
                // Move to the next phase; even phase index lights the LED
                phase_index_next = phase_inc[lbps_pkg::PHASE_W-1:0];
                ticks_left_next  =
                    lbps_pkg::ROW_LEN[pattern_sel_reg][phase_inc[lbps_pkg::PHASE_W-1:0]];
                led_level_next   = phase_index_reg[0];
            end else if (reps_cur == '0 || rep_inc < reps_cur) begin
                // Restart the pattern for another repeat
                phase_index_next  = '0;
                repeat_count_next = (reps_cur == '0) ? repeat_count_reg : rep_inc;
                ticks_left_next   = lbps_pkg::ROW_LEN[pattern_sel_reg][0];
                led_level_next    = 1'b1;
            end else begin
                // Repeats used up: go dark and idle
                pattern_sel_next  = '0;
                phase_index_next  = '0;
                repeat_count_next = '0;
                ticks_left_next   = '0;
                led_level_next    = 1'b0;
                playing_next      = 1'b0;
            end
        end else begin
            // Tick while idle: nothing changes
            playing_next = playing_reg;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (take) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Update state and result together; the state is the result payload
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_sel_reg  <= '0;
            phase_index_reg  <= '0;
            repeat_count_reg <= '0;
            ticks_left_reg   <= '0;
            led_level_reg    <= 1'b0;
            playing_reg      <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (take) begin
                pattern_sel_reg  <= pattern_sel_next;
                phase_index_reg  <= phase_index_next;
                repeat_count_reg <= repeat_count_next;
                ticks_left_reg   <= ticks_left_next;
                led_level_reg    <= led_level_next;
                playing_reg      <= playing_next;
            end
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_led_on = led_level_reg;
    assign m_active = playing_reg;

    a_dark_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !playing_reg |-> !led_level_reg)
        else $error("LED lit while no pattern plays");

    a_phase_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        playing_reg |-> ({1'b0, phase_index_reg} < lbps_pkg::row_phases(pattern_sel_reg)))
        else $error("phase index beyond the pattern's phase count");

    a_known_pattern: assert property (@(posedge aclk) disable iff (!aresetn)
        playing_reg |-> ({1'b0, pattern_sel_reg} < lbps_pkg::NUM_PATTERNS))
        else $error("playing a pattern number that does not exist");

    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !take |=> ($stable(led_level_reg) && $stable(playing_reg) && $stable(ticks_left_reg)))
        else $error("state changed without an item");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !take)
        else $error("result overwritten before it was taken");

endmodule
